>>> rtl/core/clp_pkg.sv
// ----------------------------------------------------------------------------
// clp_pkg: shared types and constants of the charlieplex LED level scanner
// Field widths of the item and result beats, opcodes and scan limits.
// ----------------------------------------------------------------------------
package clp_pkg;

    localparam int OPCODE_W     = 2;
    localparam int LED_IDX_W    = 5;
    localparam int LEVEL_W      = 2;
    localparam int LINE_FIELD_W = 5;
    localparam int PASS_W       = 2;

    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FILL  = 2'd2;

    localparam logic [PASS_W-1:0] FIRST_PASS = 2'd1;
    localparam logic [PASS_W-1:0] LAST_PASS  = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [LED_IDX_W-1:0] led_index;
        logic [LEVEL_W-1:0]   level;
    } t_item;

    typedef struct packed {
        logic [LINE_FIELD_W-1:0] line_enable;
        logic [LINE_FIELD_W-1:0] line_high;
        logic [LEVEL_W-1:0]      led_level;
    } t_result;

    // Update command from the pipeline to the level store.
    typedef struct packed {
        logic                 write;
        logic                 fill;
        logic [LED_IDX_W-1:0] led_index;
        logic [LEVEL_W-1:0]   level;
    } t_store_cmd;

endpackage

>>> rtl/core/clp_if.sv
// ----------------------------------------------------------------------------
// clp_if: valid/ready channels of the charlieplex LED level scanner
// One interface for the item channel and one for the result channel.
// ----------------------------------------------------------------------------
interface clp_item_if;
    logic           valid;
    logic           ready;
    clp_pkg::t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface clp_result_if;
    logic             valid;
    logic             ready;
    clp_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/clp_store.sv
// ----------------------------------------------------------------------------
// clp_store: brightness level store
// One 2-bit level per LED, kept as one row per line. Single writes and a
// broadcast fill; one row read for the scan and one LED read for the report.
// ----------------------------------------------------------------------------
module clp_store #(
    parameter int NUM_LINES = 5
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  clp_pkg::t_store_cmd                           i_cmd,
    input  logic [$clog2(NUM_LINES)-1:0]                  i_row_sel,
    output logic [NUM_LINES-2:0][clp_pkg::LEVEL_W-1:0]    o_row,
    output logic [clp_pkg::LEVEL_W-1:0]                   o_led_level
);

    localparam int LedsPerLine = NUM_LINES - 1;

    logic [clp_pkg::LEVEL_W-1:0] r_lv [NUM_LINES][LedsPerLine];
    logic [clp_pkg::LEVEL_W-1:0] n_lv [NUM_LINES][LedsPerLine];

    // LED number line*(NUM_LINES-1)+position sits in row line, column position.
    // Numbers past the last LED match no entry, so they are neither written nor read.
    always_comb begin
        for (int l = 0; l < NUM_LINES; l++) begin
            for (int p = 0; p < LedsPerLine; p++) begin
                n_lv[l][p] = r_lv[l][p];
                if (i_cmd.fill) begin
                    n_lv[l][p] = i_cmd.level;
                end else if (i_cmd.write && (int'(i_cmd.led_index) == l * LedsPerLine + p)) begin
                    n_lv[l][p] = i_cmd.level;
                end
            end
        end
    end

    always_comb begin
        o_led_level = '0;
        for (int l = 0; l < NUM_LINES; l++) begin
            for (int p = 0; p < LedsPerLine; p++) begin
                if (int'(i_cmd.led_index) == l * LedsPerLine + p) begin
                    o_led_level = n_lv[l][p];
                end
            end
        end
    end

    always_comb begin
        for (int p = 0; p < LedsPerLine; p++) begin
            o_row[p] = r_lv[i_row_sel][p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LINES; l++) begin
                for (int p = 0; p < LedsPerLine; p++) begin
                    r_lv[l][p] <= '0;
                end
            end
        end else begin
            r_lv <= n_lv;
        end
    end

endmodule

>>> rtl/core/clp_scan.sv
// ----------------------------------------------------------------------------
// clp_scan: scan position and line drive pattern
// Holds the pass and line of the scan and the last drive pattern; on a tick
// builds the pattern of the current line from its row of levels and advances.
// ----------------------------------------------------------------------------
module clp_scan #(
    parameter int NUM_LINES = 5
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_tick,
    input  logic [NUM_LINES-2:0][clp_pkg::LEVEL_W-1:0] i_row,
    output logic [$clog2(NUM_LINES)-1:0]               o_row_sel,
    output logic [NUM_LINES-1:0]                       o_drive_enable,
    output logic [NUM_LINES-1:0]                       o_drive_high
);

    localparam int LineW = $clog2(NUM_LINES);

    logic [clp_pkg::PASS_W-1:0] r_pass;
    logic [clp_pkg::PASS_W-1:0] n_pass;
    logic [LineW-1:0]           r_line;
    logic [LineW-1:0]           n_line;
    logic [NUM_LINES-1:0]       r_en;
    logic [NUM_LINES-1:0]       r_hi;
    logic [NUM_LINES-1:0]       tick_en;
    logic [NUM_LINES-1:0]       tick_hi;
    logic                       lit;

    assign lit = |i_row;

    // The row lists the other lines in ascending order, so a line below the
    // scanned one sits at its own position and a line above it one lower.
    for (genvar o = 0; o < NUM_LINES; o++) begin : g_line
        logic [clp_pkg::LEVEL_W-1:0] lvl;
        if (o == 0) begin : g_first
            assign lvl = i_row[0];
        end else if (o == NUM_LINES - 1) begin : g_last
            assign lvl = i_row[o-1];
        end else begin : g_mid
            assign lvl = (LineW'(o) < r_line) ? i_row[o] : i_row[o-1];
        end
        assign tick_hi[o] = lit && (r_line != LineW'(o)) && (lvl >= r_pass);
    end

    assign tick_en = tick_hi | (lit ? (NUM_LINES'(1) << r_line) : '0);

    always_comb begin
        n_line = r_line;
        n_pass = r_pass;
        if (i_tick) begin
            if (r_line == LineW'(NUM_LINES - 1)) begin
                n_line = '0;
                n_pass = (r_pass >= clp_pkg::LAST_PASS) ? clp_pkg::FIRST_PASS
                                                        : r_pass + 2'd1;
            end else begin
                n_line = r_line + 1'b1;
            end
        end
    end

    assign o_row_sel      = r_line;
    assign o_drive_enable = i_tick ? tick_en : r_en;
    assign o_drive_high   = i_tick ? tick_hi : r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= clp_pkg::FIRST_PASS;
            r_line <= '0;
            r_en   <= '0;
            r_hi   <= '0;
        end else begin
            r_pass <= n_pass;
            r_line <= n_line;
            r_en   <= o_drive_enable;
            r_hi   <= o_drive_high;
        end
    end

endmodule

>>> rtl/core/charlieplex_led_level_scanner_top.sv
// ----------------------------------------------------------------------------
// charlieplex_led_level_scanner_top: charlieplexed LED brightness scanner
// Level store, scan sequencer and a two-register valid/ready pipeline.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the result register can empty and
// returns exactly one result beat per item, in order. An item is held in the
// input register until the result register is free; there the store update,
// the drive pattern of a tick and the level report are all formed, and it
// then sits in the result register until it is taken. The input register
// takes a new item in the same cycle as its held item moves on. Ticks walk
// lines 0 to NUM_LINES-1 within passes 1 to 3; write and fill beats repeat
// the last drive pattern. Line outputs are five bits wide: unused upper bits
// read 0, lines past the fifth are not shown. Reset clears all levels at once.
module charlieplex_led_level_scanner_top #(
    parameter int NUM_LINES = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    clp_item_if.sink            i_item,
    clp_result_if.source        o_result
);

    localparam int LineW = $clog2(NUM_LINES);

    logic                       r_in_valid;
    clp_pkg::t_item             r_in;
    logic                       r_out_valid;
    clp_pkg::t_result           r_out;
    logic                       advance;
    clp_pkg::t_store_cmd        store_cmd;
    logic                       tick;
    logic [LineW-1:0]           row_sel;
    logic [NUM_LINES-2:0][clp_pkg::LEVEL_W-1:0] row;
    logic [clp_pkg::LEVEL_W-1:0] led_level;
    logic [NUM_LINES-1:0]       drive_enable;
    logic [NUM_LINES-1:0]       drive_high;
    clp_pkg::t_result           result;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    assign store_cmd.write     = advance && (r_in.opcode == clp_pkg::OP_WRITE);
    assign store_cmd.fill      = advance && (r_in.opcode == clp_pkg::OP_FILL);
    assign store_cmd.led_index = r_in.led_index;
    assign store_cmd.level     = r_in.level;
    assign tick                = advance && (r_in.opcode == clp_pkg::OP_TICK);

    clp_store #(
        .NUM_LINES (NUM_LINES)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (store_cmd),
        .i_row_sel   (row_sel),
        .o_row       (row),
        .o_led_level (led_level)
    );

    clp_scan #(
        .NUM_LINES (NUM_LINES)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (tick),
        .i_row          (row),
        .o_row_sel      (row_sel),
        .o_drive_enable (drive_enable),
        .o_drive_high   (drive_high)
    );

    for (genvar j = 0; j < clp_pkg::LINE_FIELD_W; j++) begin : g_field
        if (j < NUM_LINES) begin : g_used
            assign result.line_enable[j] = drive_enable[j];
            assign result.line_high[j]   = drive_high[j];
        end else begin : g_unused
            assign result.line_enable[j] = 1'b0;
            assign result.line_high[j]   = 1'b0;
        end
    end
    assign result.led_level = led_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule

>>> rtl/core/clp_checker.sv
// ----------------------------------------------------------------------------
// clp_checker: port-level checks of the charlieplex LED level scanner
// Watches the result channel for stall behavior and legal drive patterns.
// ----------------------------------------------------------------------------
module clp_checker #(
    parameter int NUM_LINES = 5
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [clp_pkg::LINE_FIELD_W-1:0]   i_line_enable,
    input logic [clp_pkg::LINE_FIELD_W-1:0]   i_line_high,
    input logic [clp_pkg::LEVEL_W-1:0]        i_led_level
);

    // A stalled result beat keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_out_valid) && !$past(i_out_ready)) |->
        (i_out_valid && $stable(i_line_enable) && $stable(i_line_high)
         && $stable(i_led_level)))
        else $error("result beat changed while stalled");

    // No line is reported high unless it is also driven.
    a_high_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_line_high & ~i_line_enable) == '0))
        else $error("line high while floating");

    // When all lines fit the field and any line is driven, exactly one driven line is the low one.
    a_one_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NUM_LINES <= clp_pkg::LINE_FIELD_W && i_out_valid && i_line_enable != '0) |->
        $onehot(i_line_enable & ~i_line_high))
        else $error("driven pattern without a single low line");

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind charlieplex_led_level_scanner_top clp_checker #(
    .NUM_LINES (NUM_LINES)
) u_clp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_line_enable (o_result.payload.line_enable),
    .i_line_high   (o_result.payload.line_high),
    .i_led_level   (o_result.payload.led_level)
);
